// ----- design/rpi_pkg.sv -----
// Shared types and constants for the radial profile interpolator.
// No dependencies; used by rpi_div, the core and the testbench.
package rpi_pkg;

  localparam int MAX_GRID    = 64;
  localparam int MAX_SPECIES = 8;
  localparam int GRID_AW     = $clog2(MAX_GRID);
  localparam int SPEC_AW     = $clog2(MAX_SPECIES);
  localparam int FRAC_BITS   = 16;

  localparam logic [2:0] CMD_QUERY = 3'd0;
  localparam logic [2:0] CMD_GRID  = 3'd1;
  localparam logic [2:0] CMD_DENS  = 3'd2;
  localparam logic [2:0] CMD_TEMP  = 3'd3;
  localparam logic [2:0] CMD_ROT   = 3'd4;

  localparam logic       CFG_GRID_POINTS   = 1'b0;
  localparam logic       CFG_SPECIES_COUNT = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BELOW = 2'd1;
  localparam logic [1:0] STAT_ABOVE = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  point_index;
    logic [2:0]  species_sel;
    logic [31:0] table_word;
    logic [31:0] rho_pos;
    logic [15:0] major_radius;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        density;
    logic [31:0]        temperature;
    logic signed [47:0] flow;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHK0, ST_CHKN, ST_SCAN, ST_DIV, ST_MUL, ST_OUT
  } state_t;

endpackage

// ----- design/rpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- design/rpi_div.sv -----
// Restoring divider for the Q0.16 interpolation fraction, one bit a cycle.
// Depends on rpi_pkg; requires dividend below divisor.
module rpi_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    dividend,
  input  logic [31:0]                    divisor,
  output logic                           done,
  output logic [rpi_pkg::FRAC_BITS-1:0]  quotient
);
  import rpi_pkg::*;

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        run;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(FRAC_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= divisor;
      quotient <= '0;
    end else if (run) begin
      // shift in one quotient bit, subtract when the divisor fits
      rem      <= fits ? 32'(shifted - {1'b0, dsr}) : shifted[31:0];
      quotient <= {quotient[FRAC_BITS-2:0], fits};
    end
  end
endmodule

// ----- design/radial_profile_interpolator_core.sv -----
// Top level of the radial profile interpolator: command decode, table RAMs,
// grid search sequencer and interpolation datapath. Depends on rpi_pkg,
// rpi_ram and rpi_div.
//
//  channel   ports                         handshake
//  --------  ----------------------------  ------------------------------
//  command   start, busy, command          taken when start & !busy
//  result    result_valid, result          one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data   written when cfg_we
//
// A table write gives no result. A query's result is registered after the
// sequencer checks the two grid ends, scans the grid RAM one point a cycle
// (ending at the last active point at the latest), runs the serial divider
// one bit a cycle, then passes the multiply, output and result register
// steps. busy is low again in the strobe cycle. An out-of-grid query goes
// from the end check straight to the output state. Reset is synchronous and
// clears the sequencer and the configuration registers; table RAMs are not
// cleared. The receiver cannot stall, so the result is shown for exactly one
// cycle.
module radial_profile_interpolator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rpi_pkg::in_word_t  command,
  output logic               result_valid,
  output rpi_pkg::out_word_t result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data
);
  import rpi_pkg::*;

  state_t state, state_next;

  logic [6:0] grid_points;
  logic [3:0] species_count;

  // latched query
  logic [31:0]        rho;
  logic [15:0]        rmaj;
  logic [SPEC_AW-1:0] sp;
  logic [GRID_AW-1:0] last;    // n - 1
  logic [GRID_AW-1:0] k;
  logic [GRID_AW-1:0] idx;
  logic [31:0]        glo;
  logic [1:0]         status;
  logic [1:0]         rd_cnt;
  logic [FRAC_BITS-1:0] frac;

  logic [31:0] d1, d2, t1, t2, rot;
  logic signed [49:0] dprod, tprod;
  logic signed [48:0] fprod;

  // clamped configuration
  logic [GRID_AW-1:0] n_last;
  logic [SPEC_AW-1:0] sp_sel;
  logic [3:0]         ns;

  always_comb begin
    if (grid_points < 7'd2) begin
      n_last = GRID_AW'(1);
    end else if (grid_points > 7'(MAX_GRID)) begin
      n_last = GRID_AW'(MAX_GRID - 1);
    end else begin
      n_last = GRID_AW'(grid_points - 7'd1);
    end
    if (species_count < 4'd2) begin
      ns = 4'd2;
    end else if (species_count > 4'(MAX_SPECIES)) begin
      ns = 4'(MAX_SPECIES);
    end else begin
      ns = species_count;
    end
    sp_sel = ({1'b0, command.species_sel} < ns) ? command.species_sel
                                                : SPEC_AW'(ns - 4'd1);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_points   <= 7'd2;
      species_count <= 4'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_POINTS) begin
        grid_points <= cfg_data;
      end else begin
        species_count <= cfg_data[3:0];
      end
    end
  end

  // ---------------- table RAMs ----------------
  logic accept, wr;
  assign accept = start && !busy;
  assign wr     = accept;

  logic [GRID_AW-1:0]         g_raddr, t_idx;
  logic [31:0]                g_rdata, d_rdata, t_rdata, r_rdata;

  rpi_ram #(.WIDTH(32), .DEPTH(MAX_GRID)) u_grid (
    .clk(clk), .we(wr && command.cmd == CMD_GRID), .waddr(command.point_index),
    .wdata(command.table_word), .raddr(g_raddr), .rdata(g_rdata));

  rpi_ram #(.WIDTH(32), .DEPTH(MAX_SPECIES * MAX_GRID)) u_dens (
    .clk(clk), .we(wr && command.cmd == CMD_DENS),
    .waddr({command.species_sel, command.point_index}),
    .wdata(command.table_word), .raddr({sp, t_idx}), .rdata(d_rdata));

  rpi_ram #(.WIDTH(32), .DEPTH(2 * MAX_GRID)) u_temp (
    .clk(clk), .we(wr && command.cmd == CMD_TEMP),
    .waddr({command.species_sel != 3'd0, command.point_index}),
    .wdata(command.table_word), .raddr({sp != '0, t_idx}), .rdata(t_rdata));

  rpi_ram #(.WIDTH(32), .DEPTH(MAX_GRID)) u_rot (
    .clk(clk), .we(wr && command.cmd == CMD_ROT), .waddr(command.point_index),
    .wdata(command.table_word), .raddr(idx), .rdata(r_rdata));

  // lower point on the first read, upper point after
  assign t_idx = (rd_cnt == 2'd0) ? idx : idx + GRID_AW'(1);

  // ---------------- search sequencer ----------------
  logic scan_stop, div_start, div_done;
  logic [FRAC_BITS-1:0] div_q;

  assign scan_stop = (k == last) || (g_rdata > rho);
  assign div_start = (state == ST_SCAN) && scan_stop;

  always_comb begin
    state_next = state;
    g_raddr    = '0;
    case (state)
      ST_IDLE: begin
        if (accept && command.cmd == CMD_QUERY) state_next = ST_CHK0;
      end
      ST_CHK0: begin
        g_raddr    = last;
        state_next = (rho < g_rdata) ? ST_OUT : ST_CHKN;
      end
      ST_CHKN: begin
        g_raddr    = GRID_AW'(1);
        state_next = (rho >= g_rdata) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        g_raddr = k + GRID_AW'(1);
        if (scan_stop) state_next = ST_DIV;
      end
      ST_DIV:  if (div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  rpi_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(rho - glo), .divisor(g_rdata - glo),
    .done(div_done), .quotient(div_q));

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rho    <= command.rho_pos;
        rmaj   <= command.major_radius;
        sp     <= sp_sel;
        last   <= n_last;
        status <= STAT_OK;
        k      <= GRID_AW'(1);
        rd_cnt <= '0;
      end
      ST_CHK0: begin
        glo <= g_rdata;
        if (rho < g_rdata) status <= STAT_BELOW;
      end
      ST_CHKN: begin
        if (rho >= g_rdata) status <= STAT_ABOVE;
      end
      ST_SCAN: begin
        // advance while the point is not above the position
        if (scan_stop) begin
          idx <= k - GRID_AW'(1);
        end else begin
          glo <= g_rdata;
          k   <= k + GRID_AW'(1);
        end
      end
      ST_DIV: begin
        if (rd_cnt != 2'd3) rd_cnt <= rd_cnt + 2'd1;
        if (rd_cnt == 2'd1) begin
          d1  <= d_rdata;
          t1  <= t_rdata;
          rot <= r_rdata;
        end
        if (rd_cnt == 2'd2) begin
          d2 <= d_rdata;
          t2 <= t_rdata;
        end
        if (div_done) frac <= div_q;
      end
      ST_MUL: begin
        dprod <= ($signed({1'b0, d2}) - $signed({1'b0, d1})) * $signed({1'b0, frac});
        tprod <= ($signed({1'b0, t2}) - $signed({1'b0, t1})) * $signed({1'b0, frac});
        fprod <= $signed(rot) * $signed({1'b0, rmaj});
      end
      default: ;
    endcase
  end

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      result.status <= status;
      if (status == STAT_OK) begin
        // p1 + floor((p2 - p1) * t / 2^16)
        result.density     <= 32'(d1 + 32'(dprod >>> FRAC_BITS));
        result.temperature <= 32'(t1 + 32'(tprod >>> FRAC_BITS));
        result.flow        <= fprod[47:0];
      end else begin
        result.density     <= '0;
        result.temperature <= '0;
        result.flow        <= '0;
      end
    end
  end

  // ---------------- assertions ----------------
  a_valid_after_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_OUT))
    else $error("result strobe without output state");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != STAT_OK) |->
      (result.density == '0 && result.temperature == '0 && result.flow == '0))
    else $error("error result carries nonzero data");

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide state");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == ST_DIV)
    else $error("divider started without entering divide state");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for radial_profile_interpolator_core: loads the profile
// tables, runs directed, register-sweep, unordered-grid and random tests, and checks
// every query result against an in-bench interpolation predictor. Depends on rpi_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import rpi_pkg::*;

  // Profile tables are loaded for the first points only; in-grid queries stay below them.
  localparam int LOADED_POINTS = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  command = '0;
  logic      result_valid;
  out_word_t result;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  radial_profile_interpolator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block: tables and registers as the predictor sees them.
  logic [31:0] grid_mem [MAX_GRID];
  logic [31:0] dens_mem [MAX_SPECIES*MAX_GRID];
  logic [31:0] temp_mem [2*MAX_GRID];
  logic [31:0] rot_mem  [MAX_GRID];
  logic [6:0]  grid_points_reg = 7'd2;
  logic [3:0]  species_count_reg = 4'd2;

  out_word_t pending_results [$];
  int        error_count = 0;
  bit        burst_mode = 1'b0;
  bit        ordered_grid = 1'b1;

  function automatic logic [31:0] lerp_fraction(logic [31:0] p1, logic [31:0] p2,
                                                logic [63:0] t);
    logic [63:0] acc;
    acc = {32'b0, p1} * (64'd65536 - t) + {32'b0, p2} * t;
    return acc[47:16];
  endfunction

  function automatic int active_points();
    if (grid_points_reg < 2) return 2;
    if (grid_points_reg > MAX_GRID) return MAX_GRID;
    return int'(grid_points_reg);
  endfunction

  // Interpolate one query against the shadow tables.
  function automatic out_word_t interpolate_profile(in_word_t w);
    out_word_t r;
    int n, ns, sp, i, trow;
    logic [63:0] span, off, t;
    logic signed [63:0] rot64, rmaj64, prod;
    n = active_points();
    ns = species_count_reg < 2 ? 2 : (species_count_reg > MAX_SPECIES ? MAX_SPECIES
         : int'(species_count_reg));
    sp = int'(w.species_sel) < ns ? int'(w.species_sel) : ns - 1;
    r = '0;
    if (w.rho_pos < grid_mem[0]) begin
      r.status = STAT_BELOW;
      return r;
    end
    if (w.rho_pos >= grid_mem[n-1]) begin
      r.status = STAT_ABOVE;
      return r;
    end
    i = 0;
    while (i < n - 1 && grid_mem[i] <= w.rho_pos) i++;
    i--;
    span = {32'b0, grid_mem[i+1]} - {32'b0, grid_mem[i]};
    off = {32'b0, w.rho_pos} - {32'b0, grid_mem[i]};
    t = (span != 0) ? (off << 16) / span : 64'd0;
    if (t > 64'd65535) t = 64'd65535;
    r.density = lerp_fraction(dens_mem[sp*MAX_GRID + i], dens_mem[sp*MAX_GRID + i + 1], t);
    trow = sp > 0 ? MAX_GRID : 0;
    r.temperature = lerp_fraction(temp_mem[trow + i], temp_mem[trow + i + 1], t);
    rot64 = $signed(rot_mem[i]);
    rmaj64 = $signed({48'b0, w.major_radius});
    prod = rot64 * rmaj64;
    r.flow = prod[47:0];
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic void apply_table_write(in_word_t w);
    case (w.cmd)
      CMD_GRID: grid_mem[w.point_index] = w.table_word;
      CMD_DENS: dens_mem[int'(w.species_sel)*MAX_GRID + int'(w.point_index)] = w.table_word;
      CMD_TEMP: temp_mem[(w.species_sel != 0 ? MAX_GRID : 0) + int'(w.point_index)] =
                w.table_word;
      CMD_ROT:  rot_mem[w.point_index] = w.table_word;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one word, hold it until taken, then update the predictor.
  // start stays high when no gap follows so back-to-back words need no dip.
  task automatic issue_word(input in_word_t w);
    int gap;
    command <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.cmd == CMD_QUERY) pending_results.push_back(interpolate_profile(w));
    else apply_table_write(w);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Registers change only with the block idle and no result pending.
  task automatic set_register(input logic idx, input logic [6:0] value);
    wait_drained();
    repeat (100) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_POINTS) grid_points_reg = value;
    else species_count_reg = value[3:0];
  endtask

  function automatic in_word_t make_word(logic [2:0] cmd, int idx, int spec,
                                         logic [31:0] value);
    in_word_t w;
    w.cmd = cmd;
    w.point_index = idx[5:0];
    w.species_sel = spec[2:0];
    w.table_word = value;
    w.rho_pos = $urandom;
    w.major_radius = $urandom;
    return w;
  endfunction

  function automatic in_word_t make_query(logic [31:0] rho, int spec, logic [15:0] rmaj);
    in_word_t w;
    w = make_word(CMD_QUERY, $urandom_range(0, 63), spec, $urandom);
    w.rho_pos = rho;
    w.major_radius = rmaj;
    return w;
  endfunction

  // Pick a position that mostly lands inside the loaded part of the grid.
  function automatic logic [31:0] pick_rho();
    int n, j, r, top;
    logic [63:0] span;
    logic [31:0] v;
    n = active_points();
    top = (n < LOADED_POINTS) ? n : LOADED_POINTS;
    r = $urandom_range(0, 99);
    if (!ordered_grid) return grid_mem[$urandom_range(0, n - 1)];
    if (r < 10) begin
      v = grid_mem[$urandom_range(0, top - 1)];
    end else if (r < 70) begin
      j = $urandom_range(0, top - 2);
      span = {32'b0, grid_mem[j+1]} - {32'b0, grid_mem[j]};
      v = grid_mem[j] + 32'({$urandom} % span);
    end else if (r < 78) begin
      v = grid_mem[0] - 1;
    end else if (r < 85) begin
      v = grid_mem[n-1] + $urandom_range(0, 3);
    end else begin
      v = $urandom;
    end
    // push positions between the loaded points and the last point past the grid
    if (v >= grid_mem[top-1] && v < grid_mem[n-1]) v = grid_mem[n-1];
    return v;
  endfunction

  // Fill the grid: increasing with mixed step sizes, or arbitrary contents.
  task automatic load_grid(input bit ordered);
    logic [31:0] g;
    int step_kind;
    ordered_grid = ordered;
    g = $urandom_range(1, 1 << 20);
    for (int p = 0; p < MAX_GRID; p++) begin
      issue_word(make_word(CMD_GRID, p, $urandom_range(0, 7), ordered ? g : $urandom));
      step_kind = $urandom_range(0, 9);
      if (step_kind == 0) g = g + 1;
      else if (step_kind < 4) g = g + $urandom_range(2, 4096);
      else g = g + $urandom_range(4097, 1 << 25);
    end
  endtask

  task automatic test_load_tables();
    load_grid(1'b1);
    for (int s = 0; s < MAX_SPECIES; s++)
      for (int p = 0; p < LOADED_POINTS; p++)
        issue_word(make_word(CMD_DENS, p, s, $urandom));
    for (int p = 0; p < LOADED_POINTS; p++) begin
      issue_word(make_word(CMD_TEMP, p, 0, $urandom));
      issue_word(make_word(CMD_TEMP, p, $urandom_range(1, 7), $urandom));
      issue_word(make_word(CMD_ROT, p, $urandom_range(0, 7), $urandom));
    end
  endtask

  // Edges of the grid, extreme values, species clamp, odd commands.
  task automatic test_directed();
    int n;
    n = active_points();
    issue_word(make_word(CMD_ROT, 0, 0, 32'h8000_0000));
    issue_word(make_word(CMD_DENS, 0, 1, 32'hFFFF_FFFF));
    issue_word(make_word(CMD_DENS, 1, 1, 32'h0000_0000));
    issue_word(make_query(grid_mem[0], 1, 16'hFFFF));
    issue_word(make_query(grid_mem[1] - 1, 1, 16'h0000));
    issue_word(make_query(grid_mem[0] - 1, 0, 16'hFFFF));
    issue_word(make_query(grid_mem[n-1], 0, 16'h1234));
    issue_word(make_query(32'h0000_0000, 0, 16'h0001));
    issue_word(make_query(32'hFFFF_FFFF, 7, 16'hFFFF));
    issue_word(make_word(CMD_ROT, 0, 0, 32'h7FFF_FFFF));
    issue_word(make_query(grid_mem[0] + 1, 7, 16'hFFFF));
    issue_word(make_word(CMD_TEMP, 0, 5, 32'hFFFF_FFFF));
    issue_word(make_query(grid_mem[0], 3, 16'h8000));
    issue_word(make_word(3'd5, 0, 0, $urandom));
    issue_word(make_word(3'd6, 63, 7, 32'hFFFF_FFFF));
    issue_word(make_word(3'd7, 17, 2, 32'h0));
    issue_word(make_query(grid_mem[0], 0, 16'hFFFF));
    issue_word(make_word(CMD_ROT, 0, 0, $urandom));
  endtask

  task automatic random_items(input int count);
    int r;
    in_word_t w;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        w = make_query(pick_rho(), $urandom_range(0, 7), $urandom);
      end else if (r < 75) begin
        w = make_word(3'($urandom_range(5, 7)), $urandom_range(0, 63),
                      $urandom_range(0, 7), $urandom);
      end else if (r < 77 && !ordered_grid) begin
        w = make_word(CMD_GRID, $urandom_range(0, 63), $urandom_range(0, 7), $urandom);
      end else begin
        w = make_word(3'($urandom_range(2, 4)), $urandom_range(0, 63),
                      $urandom_range(0, 7), $urandom);
      end
      issue_word(w);
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  // Walk grid_points and species_count through the extremes and beyond.
  task automatic test_register_sweep();
    logic [6:0] gp_set [6] = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd65};
    logic [6:0] sc_set [6] = '{7'd8, 7'd2, 7'd0, 7'h7F, 7'd1, 7'd5};
    for (int k = 0; k < 6; k++) begin
      set_register(CFG_GRID_POINTS, gp_set[k]);
      set_register(CFG_SPECIES_COUNT, sc_set[k]);
      random_items(15);
    end
  endtask

  task automatic test_unordered_grid();
    set_register(CFG_GRID_POINTS, 7'd16);
    load_grid(1'b0);
    random_items(40);
    wait_drained();
    load_grid(1'b1);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      set_register(CFG_GRID_POINTS, ph == 0 ? 7'd64 : 7'($urandom_range(2, 64)));
      set_register(CFG_SPECIES_COUNT, 7'($urandom_range(2, 8)));
      burst_mode = (ph == 2);
      random_items(15);
    end
    burst_mode = 1'b0;
  endtask

  // Compare each result strobe with the oldest expected result.
  always @(posedge clk) begin
    out_word_t exp_word;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result %p", result);
      end else begin
        exp_word = pending_results.pop_front();
        if (result.density !== exp_word.density ||
            result.temperature !== exp_word.temperature ||
            result.flow !== exp_word.flow || result.status !== exp_word.status) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected dens %h temp %h flow %h stat %0d, got %h %h %h %0d",
                     exp_word.density, exp_word.temperature, exp_word.flow,
                     exp_word.status, result.density, result.temperature,
                     result.flow, result.status);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_tables();
    test_directed();
    test_register_sweep();
    test_unordered_grid();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
